[rtl/opr_pkg.sv]
// Shared types and fixed field widths for the optimal page replacement unit.
`default_nettype none

package opr_pkg;

	localparam int PAGE_W  = 16;
	localparam int IDX_W   = 6;
	localparam int SLOT_W  = 3;
	localparam int TOTAL_W = 7;
	localparam int FCNT_W  = 4;

	localparam logic [FCNT_W-1:0] FRAME_COUNT_RESET = 4'd3;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic              last;
	} opr_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   ref_index;
		logic [PAGE_W-1:0]  ref_page;
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               evicted_valid;
		logic [PAGE_W-1:0]  evicted_page;
		logic [TOTAL_W-1:0] fault_total;
		logic               overflow;
		logic               done_res;
	} opr_result_t;

endpackage

`default_nettype wire

[rtl/opr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
`default_nettype none

module opr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/optimal_page_replacement_unit.sv]
// Top level of the optimal (farthest next use) page replacement unit.
//
// Load a reference string one page per item beat, one beat per cycle, into a
// reference store RAM of MAX_REFS entries; beats beyond capacity are dropped
// and reported through the overflow field. The beat with last set starts the
// replay, during which no item is taken; a start state follows that beat
// and reads the first reference. Each stored reference then yields one
// result beat: a hit or a fill of an empty frame commits straight after
// evaluation, and an eviction first scans the later references, stopping once
// every frame's next use is known or the string ends. A result beat still
// waiting on result_ready holds the replay at its next commit. All of this is
// bounded by the single read port of the reference store, which serves both
// the replay and the look-ahead scan. frame_count is sampled when the last
// item is taken; 0 acts as 1 and values above MAX_FRAMES act as MAX_FRAMES.
`default_nettype none

module optimal_page_replacement_unit #(
	parameter int MAX_REFS   = 64,
	parameter int MAX_FRAMES = 8
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_ready,
	input  wire opr_pkg::opr_item_t              item,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output opr_pkg::opr_result_t                 result,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [opr_pkg::FCNT_W-1:0]      cfg_data
);

	import opr_pkg::*;

	localparam int CNT_W  = $clog2(MAX_REFS + 1);
	localparam int ADDR_W = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
	localparam int NF_W   = $clog2(MAX_FRAMES + 1);
	localparam int LANE_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CMP_W  = (FCNT_W > NF_W) ? FCNT_W : NF_W;

	localparam logic [CNT_W-1:0] REFS_MAX   = CNT_W'(MAX_REFS);
	localparam logic [NF_W-1:0]  FRAMES_MAX = NF_W'(MAX_FRAMES);

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_LOAD   = 3'd0;
	localparam logic [ST_W-1:0] ST_START  = 3'd1;
	localparam logic [ST_W-1:0] ST_EVAL   = 3'd2;
	localparam logic [ST_W-1:0] ST_SCAN   = 3'd3;
	localparam logic [ST_W-1:0] ST_COMMIT = 3'd4;

	// control state
	logic [ST_W-1:0]        state_q, state_d;
	logic [CNT_W-1:0]       cnt_q;
	logic                   ovf_q;
	logic [FCNT_W-1:0]      fcount_q;
	logic [NF_W-1:0]        nf_q;
	logic [MAX_FRAMES-1:0]  frame_valid_q;
	logic                   out_valid_q;

	// datapath registers
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       scan_q;
	logic [CNT_W-1:0]       fault_q;
	logic [PAGE_W-1:0]      page_q;
	logic [PAGE_W-1:0]      frame_page_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0]  found_q;
	logic [LANE_W-1:0]      slot_q;
	logic                   hit_q;
	logic                   evict_q;
	opr_result_t            out_q;

	// RAM ports
	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;
	logic [PAGE_W-1:0]      rd_data;
	logic                   wr_en;

	// derived signals
	logic                   item_fire;
	logic                   commit_fire;
	logic [NF_W-1:0]        nf_eff;
	logic [MAX_FRAMES-1:0]  lane_used;
	logic [MAX_FRAMES-1:0]  hit_vec;
	logic [MAX_FRAMES-1:0]  empty_vec;
	logic [MAX_FRAMES-1:0]  match_vec;
	logic [MAX_FRAMES-1:0]  newly_vec;
	logic [MAX_FRAMES-1:0]  found_next;
	logic [MAX_FRAMES-1:0]  unfound_vec;
	logic                   all_found;
	logic [CNT_W-1:0]       idx_next;
	logic [CNT_W-1:0]       scan_next;
	logic                   idx_more;
	logic                   scan_more;
	logic                   done;
	logic [CNT_W-1:0]       fault_new;

	// lowest set lane of a vector
	function automatic logic [LANE_W-1:0] lowest(input logic [MAX_FRAMES-1:0] v);
		logic [LANE_W-1:0] r;
		r = '0;
		for (int j = MAX_FRAMES - 1; j >= 0; j--) begin
			if (v[j]) begin
				r = LANE_W'(j);
			end
		end
		return r;
	endfunction

	assign item_ready   = (state_q == ST_LOAD);
	assign item_fire    = item_valid && item_ready;
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign commit_fire  = (state_q == ST_COMMIT) && (!out_valid_q || result_ready);
	assign wr_en        = item_fire && (cnt_q < REFS_MAX);

	// reference store
	opr_ram #(
		.WIDTH (PAGE_W),
		.DEPTH (MAX_REFS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ADDR_W'(cnt_q)),
		.wdata (item.page),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// clamp the configured frame count into the supported range
	always_comb begin
		if (fcount_q == '0) begin
			nf_eff = NF_W'(1);
		end else if (CMP_W'(fcount_q) > CMP_W'(FRAMES_MAX)) begin
			nf_eff = FRAMES_MAX;
		end else begin
			nf_eff = NF_W'(fcount_q);
		end
	end

	// per-frame lane compares
	always_comb begin
		for (int j = 0; j < MAX_FRAMES; j++) begin
			lane_used[j] = (NF_W'(j) < nf_q);
			hit_vec[j]   = frame_valid_q[j] && (frame_page_q[j] == rd_data);
			empty_vec[j] = lane_used[j] && !frame_valid_q[j];
			match_vec[j] = lane_used[j] && (frame_page_q[j] == rd_data);
		end
	end

	assign newly_vec   = match_vec & ~found_q;
	assign found_next  = found_q | match_vec;
	assign unfound_vec = lane_used & ~found_next;
	assign all_found   = (unfound_vec == '0);
	assign idx_next    = idx_q + 1'b1;
	assign scan_next   = scan_q + 1'b1;
	assign idx_more    = (idx_next < cnt_q);
	assign scan_more   = (scan_next < cnt_q);
	assign done        = (idx_next == cnt_q);
	assign fault_new   = hit_q ? fault_q : fault_q + 1'b1;

	// next state and store read requests
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			ST_LOAD: begin
				if (item_fire && item.last) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				rd_en   = 1'b1;
				rd_addr = ADDR_W'(idx_q);
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if ((|hit_vec) || (|empty_vec) || !idx_more) begin
					state_d = ST_COMMIT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(idx_next);
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (all_found || !scan_more) begin
					state_d = ST_COMMIT;
				end else begin
					rd_en   = 1'b1;
					rd_addr = ADDR_W'(scan_next);
				end
			end
			ST_COMMIT: begin
				if (commit_fire) begin
					if (done) begin
						state_d = ST_LOAD;
					end else begin
						rd_en   = 1'b1;
						rd_addr = ADDR_W'(idx_next);
						state_d = ST_EVAL;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			cnt_q         <= '0;
			ovf_q         <= 1'b0;
			fcount_q      <= FRAME_COUNT_RESET;
			nf_q          <= '0;
			frame_valid_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				fcount_q <= cfg_data;
			end
			// store or drop the incoming reference; empty frames on the last beat
			if (item_fire) begin
				if (cnt_q < REFS_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
				if (item.last) begin
					frame_valid_q <= '0;
					nf_q          <= nf_eff;
				end
			end
			// load the result register, or drain it once taken
			if (commit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit_fire) begin
				if (!hit_q) begin
					frame_valid_q[slot_q] <= 1'b1;
				end
				if (done) begin
					cnt_q <= '0;
					ovf_q <= 1'b0;
				end
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (item_fire && item.last) begin
			idx_q   <= '0;
			fault_q <= '0;
		end
		// classify the reference just read
		if (state_q == ST_EVAL) begin
			page_q  <= rd_data;
			found_q <= '0;
			scan_q  <= idx_next;
			if (|hit_vec) begin
				hit_q   <= 1'b1;
				evict_q <= 1'b0;
				slot_q  <= lowest(hit_vec);
			end else if (|empty_vec) begin
				hit_q   <= 1'b0;
				evict_q <= 1'b0;
				slot_q  <= lowest(empty_vec);
			end else begin
				hit_q   <= 1'b0;
				evict_q <= 1'b1;
				slot_q  <= '0;
			end
		end
		// look ahead: take the last frame found (farthest next use) or lowest unfound
		if (state_q == ST_SCAN) begin
			found_q <= found_next;
			scan_q  <= scan_next;
			if (all_found) begin
				slot_q <= lowest(newly_vec);
			end else if (!scan_more) begin
				slot_q <= lowest(unfound_vec);
			end
		end
		// retire the reference: update frames and load the result beat
		if (commit_fire) begin
			if (!hit_q) begin
				frame_page_q[slot_q] <= page_q;
				fault_q              <= fault_new;
			end
			idx_q               <= idx_next;
			out_q.ref_index     <= IDX_W'(idx_q);
			out_q.ref_page      <= page_q;
			out_q.hit           <= hit_q;
			out_q.slot          <= SLOT_W'(slot_q);
			out_q.evicted_valid <= evict_q;
			out_q.evicted_page  <= evict_q ? frame_page_q[slot_q] : '0;
			out_q.fault_total   <= TOTAL_W'(fault_new);
			out_q.overflow      <= ovf_q;
			out_q.done_res      <= done;
		end
	end

endmodule

`default_nettype wire

[tb/sv/optimal_page_replacement_unit_tb.sv]
// Self-checking testbench for the optimal page replacement unit.
`default_nettype none

module optimal_page_replacement_unit_tb;
	import opr_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int FRAME_SLOTS = 8;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_OFF_CYCLES = 400;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	opr_item_t   item;
	logic        result_valid;
	logic        result_ready;
	opr_result_t result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [FCNT_W-1:0] cfg_data;

	// prediction state: the string loaded so far and the frame setting
	logic [PAGE_W-1:0] loaded_refs[$];
	bit                refs_dropped;
	logic [FCNT_W-1:0] frame_setting;
	opr_result_t       pending_results[$];

	// stimulus scratch and bookkeeping
	logic [PAGE_W-1:0] ref_buf[$];
	bit idle_on;
	int rx_hold;
	int failures;
	int mismatches;
	int results_seen;
	int strings_played;
	int refs_stored;
	int cfg_writes;

	optimal_page_replacement_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Replay the loaded string with farthest-next-use replacement and queue
	// one expected result per stored reference.
	function automatic void replay_string();
		logic [PAGE_W-1:0] fpage[FRAME_SLOTS];
		bit fvalid[FRAME_SLOTS];
		int nf, n, faults, slot, victim, best_next, nxt, i, j, k;
		bit hit, filled, dead, used;
		opr_result_t r;
		nf = (frame_setting == 0) ? 1 :
			(frame_setting > FRAME_SLOTS) ? FRAME_SLOTS : int'(frame_setting);
		n = loaded_refs.size();
		faults = 0;
		for (j = 0; j < FRAME_SLOTS; j++) begin
			fpage[j] = '0;
			fvalid[j] = 1'b0;
		end
		for (i = 0; i < n; i++) begin
			r = '0;
			hit = 1'b0;
			filled = 1'b0;
			slot = 0;
			for (j = 0; j < nf && !hit; j++)
				if (fvalid[j] && fpage[j] == loaded_refs[i]) begin
					hit = 1'b1;
					slot = j;
				end
			if (!hit) begin
				for (j = 0; j < nf && !filled; j++)
					if (!fvalid[j]) begin
						filled = 1'b1;
						slot = j;
					end
				if (!filled) begin
					// lowest dead page first, else farthest next use
					victim = 0;
					best_next = 0;
					dead = 1'b0;
					for (j = 0; j < nf && !dead; j++) begin
						used = 1'b0;
						nxt = 0;
						for (k = i + 1; k < n && !used; k++)
							if (loaded_refs[k] == fpage[j]) begin
								used = 1'b1;
								nxt = k;
							end
						if (!used) begin
							victim = j;
							dead = 1'b1;
						end else if (j == 0 || nxt > best_next) begin
							victim = j;
							best_next = nxt;
						end
					end
					slot = victim;
					r.evicted_valid = 1'b1;
					r.evicted_page = fpage[slot];
				end
				fpage[slot] = loaded_refs[i];
				fvalid[slot] = 1'b1;
				faults++;
			end
			r.ref_index = i[IDX_W-1:0];
			r.ref_page = loaded_refs[i];
			r.hit = hit;
			r.slot = slot[SLOT_W-1:0];
			r.fault_total = faults[TOTAL_W-1:0];
			r.overflow = refs_dropped;
			r.done_res = (i + 1 == n);
			pending_results.push_back(r);
		end
		loaded_refs.delete();
		refs_dropped = 1'b0;
		strings_played++;
	endfunction

	// Store one accepted beat; a last beat triggers the replay.
	function automatic void absorb_ref(opr_item_t beat);
		if (loaded_refs.size() < STORE_DEPTH) begin
			loaded_refs.push_back(beat.page);
			refs_stored++;
		end else begin
			refs_dropped = 1'b1;
		end
		if (beat.last)
			replay_string();
	endfunction

	// Offer one reference beat, after a random gap if idle_on, and wait for acceptance.
	task automatic send_ref(input logic [PAGE_W-1:0] pg, input logic lst);
		opr_item_t beat;
		int gap;
		beat.page = pg;
		beat.last = lst;
		gap = idle_on ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= beat;
		do @(posedge clk); while (!item_ready);
		absorb_ref(beat);
	endtask

	// Send ref_buf as one string, last flag on the final entry.
	task automatic play_string();
		int i;
		for (i = 0; i < ref_buf.size(); i++)
			send_ref(ref_buf[i], i == ref_buf.size() - 1);
	endtask

	// Drop valid, wait for every expected result, then let the block go quiet.
	task automatic settle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the frame count register; call only when the block is idle.
	task automatic write_frames(input logic [FCNT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		frame_setting = value;
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Fill ref_buf with len references drawn mostly from a small page pool.
	task automatic build_string(input int len, input int pool_size);
		logic [PAGE_W-1:0] pool[$];
		int i;
		ref_buf.delete();
		for (i = 0; i < pool_size; i++)
			pool.push_back(PAGE_W'($urandom));
		for (i = 0; i < len; i++)
			if ($urandom_range(0, 9) == 0)
				ref_buf.push_back(PAGE_W'($urandom));
			else
				ref_buf.push_back(pool[$urandom_range(0, pool_size - 1)]);
	endtask

	// Reset-value frames, a one-reference string, a textbook string, one frame.
	task automatic test_short_strings();
		idle_on = 1'b1;
		ref_buf = '{16'hFFFF};
		play_string();
		ref_buf = '{16'd7, 16'd0, 16'd1, 16'd2, 16'd0, 16'd3, 16'd0,
			16'd4, 16'd2, 16'd3, 16'd0, 16'd3, 16'd2};
		play_string();
		settle();
		write_frames(4'd1);
		ref_buf = '{16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd1};
		play_string();
		settle();
	endtask

	// Frame count below and above range, and the exact maximum.
	task automatic test_frame_limits();
		write_frames(4'd0);
		ref_buf = '{16'h0001, 16'h0002, 16'h0001, 16'h0003, 16'h0002, 16'h0002};
		play_string();
		settle();
		write_frames(4'd15);
		ref_buf = '{16'h8000, 16'h4000, 16'h2000, 16'h1000, 16'h0800, 16'h0400,
			16'h0200, 16'h0100, 16'h0080, 16'h8000, 16'h0040, 16'h4000};
		play_string();
		settle();
		write_frames(4'd8);
		build_string(14, 10);
		play_string();
		settle();
	endtask

	// Fill the store: dropped last beat, exactly full, one beyond.
	task automatic test_store_overflow();
		write_frames(4'd4);
		build_string(70, 6);
		play_string();
		build_string(STORE_DEPTH, 7);
		play_string();
		build_string(STORE_DEPTH + 1, 5);
		play_string();
		settle();
	endtask

	// Hold the receiver off while two strings are offered back to back.
	task automatic test_stall_pressure();
		write_frames(4'd3);
		idle_on = 1'b0;
		rx_hold = HOLD_OFF_CYCLES;
		build_string(24, 5);
		play_string();
		build_string(24, 6);
		play_string();
		settle();
		idle_on = 1'b1;
	endtask

	// Random strings with random frame settings and pacing.
	task automatic test_random_strings();
		int goal, len;
		goal = refs_stored + 100;
		while (refs_stored < goal) begin
			if ($urandom_range(0, 2) == 0) begin
				settle();
				write_frames(FCNT_W'($urandom_range(0, 15)));
			end
			idle_on = ($urandom_range(0, 3) != 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
				: $urandom_range(1, 24);
			build_string(len, $urandom_range(1, 10));
			play_string();
		end
		idle_on = 1'b1;
		settle();
	endtask

	// Pace result_ready: random stalls per beat if idle_on, plus an occasional long hold.
	initial begin : result_pacing
		int stall;
		result_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				result_ready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end
			stall = idle_on ? $urandom_range(0, 19) : 0;
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid && rx_hold == 0);
		end
	end

	// Compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin : check_results
		opr_result_t want;
		string bad_fields;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result beat: index %0d page %h",
						result.ref_index, result.ref_page);
			end else begin
				want = pending_results.pop_front();
				bad_fields = "";
				if (want.ref_index !== result.ref_index) bad_fields = {bad_fields, " ref_index"};
				if (want.ref_page !== result.ref_page) bad_fields = {bad_fields, " ref_page"};
				if (want.hit !== result.hit) bad_fields = {bad_fields, " hit"};
				if (want.slot !== result.slot) bad_fields = {bad_fields, " slot"};
				if (want.evicted_valid !== result.evicted_valid)
					bad_fields = {bad_fields, " evicted_valid"};
				if (want.evicted_page !== result.evicted_page)
					bad_fields = {bad_fields, " evicted_page"};
				if (want.fault_total !== result.fault_total)
					bad_fields = {bad_fields, " fault_total"};
				if (want.overflow !== result.overflow) bad_fields = {bad_fields, " overflow"};
				if (want.done_res !== result.done_res) bad_fields = {bad_fields, " done_res"};
				if (bad_fields != "") begin
					failures++;
					mismatches++;
					if (failures <= 10) begin
						$display("mismatch on%s", bad_fields);
						$display("  expected idx %0d page %h hit %b slot %0d ev %b/%h faults %0d ovf %b done %b",
							want.ref_index, want.ref_page, want.hit, want.slot,
							want.evicted_valid, want.evicted_page, want.fault_total,
							want.overflow, want.done_res);
						$display("  actual   idx %0d page %h hit %b slot %0d ev %b/%h faults %0d ovf %b done %b",
							result.ref_index, result.ref_page, result.hit, result.slot,
							result.evicted_valid, result.evicted_page, result.fault_total,
							result.overflow, result.done_res);
					end
				end
			end
		end
	end

	// Bound the run.
	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		idle_on = 1'b1;
		rx_hold = 0;
		failures = 0;
		mismatches = 0;
		results_seen = 0;
		strings_played = 0;
		refs_stored = 0;
		cfg_writes = 0;
		refs_dropped = 1'b0;
		frame_setting = FRAME_COUNT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_short_strings();
		test_frame_limits();
		test_store_overflow();
		test_stall_pressure();
		test_random_strings();

		if (pending_results.size() != 0) begin
			failures++;
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("Replayed %0d strings from %0d stored references; %0d results checked, %0d off.",
			strings_played, refs_stored, results_seen, mismatches);
		$display("%0d frame count writes incl. 0, 1, 8, 15; store overflow and long hold-off run.",
			cfg_writes);
		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
